### hw/rtl/assert_macros.svh
// Assertion macros used by weighted_phmm_transition_tally.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clk_i edge, off while rst_ni is low.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every rising clk_i edge, reset included.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hw/rtl/wptt_pkg.sv
package wptt_pkg;

  localparam int unsigned DefMaxModules = 256;
  localparam int unsigned NumTypes      = 9;

  localparam int unsigned WeightW = 16;
  localparam int unsigned TotalW  = 32;
  localparam int unsigned RdModW  = 8;
  localparam int unsigned RdTypeW = 4;
  localparam int unsigned CodeW   = 2;

  // Item kinds
  localparam logic KindCell = 1'b0;
  localparam logic KindRead = 1'b1;

  // State codes of an alignment cell
  localparam logic [CodeW-1:0] CodeDelete = 2'd0;
  localparam logic [CodeW-1:0] CodeMatch  = 2'd1;
  localparam logic [CodeW-1:0] CodeInsert = 2'd2;
  localparam logic [CodeW-1:0] CodeNa     = 2'd3;

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StExec
  } ctrl_state_e;

endpackage

### hw/rtl/wptt_intf.sv
interface wptt_in_if
  import wptt_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [CodeW-1:0]   state_code;
  logic [WeightW-1:0] weight;
  logic               row_end;
  logic [RdModW-1:0]  read_module;
  logic [RdTypeW-1:0] read_type;

  modport source (
    output valid, kind, state_code, weight, row_end, read_module, read_type,
    input  ready
  );
  modport sink (
    input  valid, kind, state_code, weight, row_end, read_module, read_type,
    output ready
  );
endinterface

interface wptt_out_if
  import wptt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [TotalW-1:0] total;
  logic              module_overflow;

  modport source (
    output valid, total, module_overflow,
    input  ready
  );
  modport sink (
    input  valid, total, module_overflow,
    output ready
  );
endinterface

### hw/rtl/weighted_phmm_transition_tally.sv
// Channel   Dir  Beat carries
// --------  ---  ---------------------------------------------------------------
// in_i      in   kind, state_code, weight, row_end, read_module, read_type
// out_o     out  total, module_overflow (one beat per read item, none per cell)
//
// Each item first issues the accumulator RAM read in StIdle, then adds and writes
// back (or loads the result register) in StExec; no new item is taken in StExec.
// After reset the RAM is swept to zero, one entry a cycle, all 9 * MAX_MODULES
// entries (2304 at the default) before the first item is taken.
// A read item whose result cannot be loaded waits in StExec until out_o frees.
// A result waiting on out_o does not block cell items.

`include "assert_macros.svh"

module weighted_phmm_transition_tally
  import wptt_pkg::*;
#(
  parameter int unsigned MAX_MODULES = DefMaxModules
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  wptt_in_if.sink            in_i,
  wptt_out_if.source         out_o
);

  localparam int unsigned Depth = NumTypes * MAX_MODULES;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned MidxW = $clog2(MAX_MODULES + 1);

  // Control and walk state
  ctrl_state_e       state_q, state_d;
  logic [AddrW-1:0]  clr_addr_q, clr_addr_d;
  logic [CodeW-1:0]  prev_q, prev_d;
  logic              have_prev_q, have_prev_d;
  logic [MidxW-1:0]  midx_q, midx_d;
  logic              ovf_q, ovf_d;

  // Item in flight
  logic              op_kind_q, op_add_q, op_rd_ok_q;
  logic              op_add_d, op_rd_ok_d;
  logic [AddrW-1:0]  op_addr_q, op_addr_d;
  logic [WeightW-1:0] op_weight_q;

  // Result register
  logic              out_valid_q, out_valid_d;
  logic [TotalW-1:0] total_q, total_d;
  logic              out_ovf_q, out_ovf_d;

  // Accumulator RAM
  logic [TotalW-1:0] mem [Depth];
  logic [TotalW-1:0] rdata_q;
  logic              mem_re, mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [TotalW-1:0] mem_wdata;

  logic              in_fire;
  logic [RdTypeW-1:0] cell_type;
  logic [TotalW:0]   sum;

  assign in_fire   = in_i.valid && in_i.ready;
  // Transition type prev*3+cur
  assign cell_type = RdTypeW'({prev_q, 1'b0}) + RdTypeW'(prev_q) + RdTypeW'(in_i.state_code);
  assign sum       = {1'b0, rdata_q} + (TotalW + 1)'(op_weight_q);

  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    prev_d      = prev_q;
    have_prev_d = have_prev_q;
    midx_d      = midx_q;
    ovf_d       = ovf_q;
    op_add_d    = 1'b0;
    op_rd_ok_d  = 1'b0;
    op_addr_d   = op_addr_q;
    out_valid_d = out_valid_q && !out_o.ready;
    total_d     = total_q;
    out_ovf_d   = out_ovf_q;
    in_i.ready  = 1'b0;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = op_addr_q;
    mem_wdata   = sum[TotalW] ? '1 : sum[TotalW-1:0];

    case (state_q)
      StClear: begin
        // Sweep the RAM to zero
        mem_we     = 1'b1;
        mem_waddr  = clr_addr_q;
        mem_wdata  = '0;
        clr_addr_d = clr_addr_q + AddrW'(1);
        if (clr_addr_q == AddrW'(Depth - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          mem_re  = 1'b1;
          state_d = StExec;
          if (in_i.kind == KindCell) begin
            if (in_i.state_code != CodeNa) begin
              if (!have_prev_q) begin
                have_prev_d = 1'b1;
              end else begin
                if (midx_q < MidxW'(MAX_MODULES)) begin
                  op_add_d  = 1'b1;
                  op_addr_d = AddrW'(cell_type) * AddrW'(MAX_MODULES) + AddrW'(midx_q);
                  if (in_i.state_code != CodeInsert) begin
                    midx_d = midx_q + MidxW'(1);
                  end
                end else begin
                  // Module past capacity: drop the add, flag it
                  ovf_d = 1'b1;
                end
              end
              prev_d = in_i.state_code;
            end
            if (in_i.row_end) begin
              have_prev_d = 1'b0;
              prev_d      = CodeDelete;
              midx_d      = '0;
            end
          end else begin
            op_rd_ok_d = (in_i.read_type < RdTypeW'(NumTypes)) &&
                         (32'(in_i.read_module) < 32'(MAX_MODULES));
            op_addr_d  = AddrW'(in_i.read_type) * AddrW'(MAX_MODULES) +
                         AddrW'(in_i.read_module);
          end
        end
      end
      StExec: begin
        if (op_kind_q == KindCell) begin
          mem_we  = op_add_q;
          state_d = StIdle;
        end else if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          total_d     = op_rd_ok_q ? rdata_q : '0;
          out_ovf_d   = ovf_q;
          state_d     = StIdle;
        end else begin
          // Hold the read until the result register frees
          op_add_d   = op_add_q;
          op_rd_ok_d = op_rd_ok_q;
        end
      end
      default: begin
        state_d = StClear;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_addr_q  <= '0;
      prev_q      <= CodeDelete;
      have_prev_q <= 1'b0;
      midx_q      <= '0;
      ovf_q       <= 1'b0;
      op_add_q    <= 1'b0;
      op_rd_ok_q  <= 1'b0;
      op_kind_q   <= KindCell;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      prev_q      <= prev_d;
      have_prev_q <= have_prev_d;
      midx_q      <= midx_d;
      ovf_q       <= ovf_d;
      op_add_q    <= op_add_d;
      op_rd_ok_q  <= op_rd_ok_d;
      if (in_fire) begin
        op_kind_q <= in_i.kind;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_addr_q <= op_addr_d;
    total_q   <= total_d;
    out_ovf_q <= out_ovf_d;
    if (in_fire) begin
      op_weight_q <= in_i.weight;
    end
  end

  // Accumulator RAM: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[op_addr_d];
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.total           = total_q;
  assign out_o.module_overflow = out_ovf_q;

  `ASSERT_CLK(a_fire_to_exec, in_fire |=> state_q == StExec, "accepted item did not execute")
  `ASSERT_CLK(a_midx_bound, midx_q <= MidxW'(MAX_MODULES), "module index past capacity")
  `ASSERT_CLK(a_ovf_sticky, ovf_q |=> ovf_q, "overflow flag cleared")
  `ASSERT_CLK_ALWAYS(a_no_in_clear, (state_q == StClear) |-> !out_valid_q,
                     "result shown during RAM clear")

endmodule
